// ===== design/idle_timeout_session_table_defines.svh =====
// Assertion macros for the session table checker.
`ifndef IDLE_TIMEOUT_SESSION_TABLE_DEFINES_SVH
`define IDLE_TIMEOUT_SESSION_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ITS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("session table check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define ITS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("session table check failed");

`endif

// ===== design/its_pkg.sv =====
// Types, constants and helpers for the idle-timeout session table.
package its_pkg;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int KEY_W           = 64;
    localparam int TIME_W          = 32;
    localparam int CNT32_W         = 32;
    localparam int PERIOD_W        = 17;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd2;

    // Request type codes
    typedef enum logic {
        REQ_ACCESS = 1'b0,
        REQ_FLUSH  = 1'b1
    } req_type_t;

    // Result kind codes
    typedef enum logic {
        RES_CLOSED  = 1'b0,
        RES_DROPPED = 1'b1
    } res_kind_t;

    typedef struct packed {
        logic              req_type;
        logic [KEY_W-1:0]  client_key;
        logic [TIME_W-1:0] timestamp_secs;
    } req_t;

    typedef struct packed {
        logic               result_kind;
        logic [KEY_W-1:0]   session_key;
        logic [TIME_W-1:0]  first_secs;
        logic [TIME_W-1:0]  last_secs;
        logic [TIME_W-1:0]  duration_secs;
        logic [CNT32_W-1:0] request_count;
        logic               last_of_run;
    } rsp_t;

    // Classified request handed from the front to the walk engine
    typedef struct packed {
        logic              is_flush;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } job_t;

    // One table entry
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  first;
        logic [TIME_W-1:0]  last;
        logic [CNT32_W-1:0] count;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH,
        ST_LAST
    } walk_state_t;

    // last - first + 1, saturating; 1 when last is before first
    function automatic logic [TIME_W-1:0] session_duration(
        input logic [TIME_W-1:0] first,
        input logic [TIME_W-1:0] last
    );
        logic [TIME_W-1:0] diff;
        diff = last - first;
        if (last < first)
            return TIME_W'(1);
        else if (diff == '1)
            return '1;
        else
            return diff + TIME_W'(1);
    endfunction

    // Saturating request count increment
    function automatic logic [CNT32_W-1:0] count_inc(input logic [CNT32_W-1:0] count);
        if (count == '1)
            return count;
        else
            return count + CNT32_W'(1);
    endfunction

endpackage

// ===== design/idle_timeout_session_table.sv =====
// Idle-timeout session table: top level with the timeout register.
//
// Request channel (req_valid / req_stall / req): an access record or an end
// item. Requests go into a two-entry queue, so up to two can be taken while
// the table walk is busy; req_stall rises when the queue is full.
// Response channel (rsp_valid / rsp_stall / rsp): closed sessions in table
// order, then a drop result if the table was full; last_of_run marks the
// final response of a request. A request with nothing to report gives none.
// Each request pops from the queue and reads the first entry, then walks the
// open sessions one entry at a time with the read pipelined one ahead, then
// appends the new session, drops the request or, for an end item, clears the
// table, plus a hand-off step when it produces responses.
// A stalled receiver holds the output register and a one-deep hold stage;
// once both are full the walk pauses at its next result until rsp_stall drops.
// Reset empties the table, clears the queue and sets the timeout to 2 s.
// cfg_wr_en / cfg_wr_data write the timeout; write only while idle.
module idle_timeout_session_table #(
    parameter int TABLE_DEPTH = its_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  its_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output its_pkg::rsp_t                 rsp,
    input  logic                          cfg_wr_en,
    input  logic [its_pkg::PERIOD_W-1:0]  cfg_wr_data
);
    import its_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic                job_valid;
    logic                job_pop;
    job_t                job;

    // Inactivity period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_wr_en)
            period_reg <= cfg_wr_data;
    end

    its_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    its_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .period    (period_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== design/its_front.sv =====
// Request front end: accepts requests, classifies them and queues them for the walk.
module its_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  its_pkg::req_t req,
    output logic          job_valid,
    output its_pkg::job_t job,
    input  logic          job_pop
);
    import its_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    job_t               q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               push, pop;
    job_t               classified;

    // Classify the incoming request
    always_comb
    begin
        classified.is_flush = (req.req_type == REQ_FLUSH);
        classified.key      = req.client_key;
        classified.now      = req.timestamp_secs;
    end

    assign req_stall = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign job_valid = (fill_reg != '0);
    assign pop       = job_pop && job_valid;
    assign job       = q_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= classified;
    end

endmodule

// ===== design/its_back.sv =====
// Walk engine: holds the session table, walks it once per request and emits results.
module its_back #(
    parameter int TABLE_DEPTH = its_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [its_pkg::PERIOD_W-1:0]  period,
    input  logic                          job_valid,
    input  its_pkg::job_t                 job,
    output logic                          job_pop,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output its_pkg::rsp_t                 rsp
);
    import its_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Table memory, one read and one write port
    entry_t             mem [TABLE_DEPTH];
    entry_t             rdata_reg;

    walk_state_t        state_reg, state_next;
    job_t               cur_reg, cur_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   w_reg, w_next;
    logic               matched_reg, matched_next;
    logic               pend_valid_reg, pend_valid_next;
    rsp_t               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    // Per-entry evaluation
    logic [TIME_W-1:0]  idle_diff;
    logic               expired;
    logic               hit;
    entry_t             upd;
    rsp_t               entry_res;
    rsp_t               drop_res;
    logic [CNT_W-1:0]   idx_inc;

    logic               out_free;
    logic               can_emit;
    logic               emit;
    rsp_t               emit_data;
    logic               do_emit;

    assign out_free = !out_valid_reg || !rsp_stall;
    assign can_emit = !pend_valid_reg || out_free;
    assign idx_inc  = rd_idx_reg + 1'b1;

    // Idle check, key match and result formatting for the entry in rdata_reg
    always_comb
    begin
        idle_diff = cur_reg.now - rdata_reg.last;
        expired   = (cur_reg.now >= rdata_reg.last) &&
                    (idle_diff > {{(TIME_W - PERIOD_W){1'b0}}, period});
        hit       = (rdata_reg.key == cur_reg.key);

        upd = rdata_reg;
        if (hit)
        begin
            upd.count = count_inc(rdata_reg.count);
            upd.last  = cur_reg.now;
        end

        entry_res.result_kind   = RES_CLOSED;
        entry_res.session_key   = rdata_reg.key;
        entry_res.first_secs    = rdata_reg.first;
        entry_res.last_secs     = rdata_reg.last;
        entry_res.duration_secs = session_duration(rdata_reg.first, rdata_reg.last);
        entry_res.request_count = rdata_reg.count;
        entry_res.last_of_run   = 1'b0;

        drop_res.result_kind   = RES_DROPPED;
        drop_res.session_key   = cur_reg.key;
        drop_res.first_secs    = cur_reg.now;
        drop_res.last_secs     = cur_reg.now;
        drop_res.duration_secs = TIME_W'(1);
        drop_res.request_count = CNT32_W'(1);
        drop_res.last_of_run   = 1'b0;
    end

    // Walk sequencer, next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        occ_next        = occ_reg;
        rd_idx_next     = rd_idx_reg;
        w_next          = w_reg;
        matched_next    = matched_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_next        = out_reg;
        job_pop         = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = w_reg[IDX_W-1:0];
        wr_data         = upd;
        emit            = 1'b0;
        emit_data       = entry_res;
        do_emit         = cur_reg.is_flush || expired;

        unique case (state_reg)
            ST_IDLE:
            begin
                job_pop = job_valid;
                if (job_valid)
                begin
                    cur_next     = job;
                    w_next       = '0;
                    matched_next = 1'b0;
                    if (occ_reg != '0)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = '0;
                        rd_idx_next = '0;
                        state_next  = ST_WALK;
                    end
                    else
                        state_next = ST_FINISH;
                end
            end

            ST_WALK:
            begin
                if (!do_emit || can_emit)
                begin
                    if (do_emit)
                        emit = 1'b1;
                    else
                    begin
                        // Keep the entry, compacted down to the write slot
                        wr_en  = 1'b1;
                        w_next = w_reg + 1'b1;
                        if (hit)
                            matched_next = 1'b1;
                    end
                    if (idx_inc < occ_reg)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = idx_inc[IDX_W-1:0];
                        rd_idx_next = idx_inc;
                    end
                    else
                        state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (cur_reg.is_flush)
                begin
                    occ_next   = '0;
                    state_next = pend_valid_reg ? ST_LAST : ST_IDLE;
                end
                else if (matched_reg)
                begin
                    occ_next   = w_reg;
                    state_next = pend_valid_reg ? ST_LAST : ST_IDLE;
                end
                else if (w_reg < CNT_W'(TABLE_DEPTH))
                begin
                    // Append a new session
                    wr_en         = 1'b1;
                    wr_data.key   = cur_reg.key;
                    wr_data.first = cur_reg.now;
                    wr_data.last  = cur_reg.now;
                    wr_data.count = CNT32_W'(1);
                    occ_next      = w_reg + 1'b1;
                    state_next    = pend_valid_reg ? ST_LAST : ST_IDLE;
                end
                else if (can_emit)
                begin
                    // Table full: drop the request
                    emit       = 1'b1;
                    emit_data  = drop_res;
                    occ_next   = w_reg;
                    state_next = ST_LAST;
                end
            end

            ST_LAST:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = pend_reg;
                    out_next.last_of_run = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new result pushes the held one out, since it is not the last
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            rd_idx_reg     <= '0;
            w_reg          <= '0;
            matched_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            rd_idx_reg     <= rd_idx_next;
            w_reg          <= w_next;
            matched_reg    <= matched_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // Table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== design/its_checker.sv =====
// Port-level checks for the session table, bound to the top level.
`include "idle_timeout_session_table_defines.svh"

module its_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input its_pkg::rsp_t rsp
);
    import its_pkg::*;

    // A stalled response stays put
    `ITS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // A drop result describes a single access
    `ITS_ASSERT_NOW(a_drop_shape, rsp_valid && (rsp.result_kind == RES_DROPPED), (rsp.duration_secs == 32'd1) && (rsp.request_count == 32'd1) && (rsp.first_secs == rsp.last_secs))

    // Durations start at one second
    `ITS_ASSERT_NOW(a_dur_nonzero, rsp_valid, rsp.duration_secs != 32'd0)

    // Every reported session saw at least one access
    `ITS_ASSERT_NOW(a_count_nonzero, rsp_valid, rsp.request_count != 32'd0)

endmodule

bind idle_timeout_session_table its_checker u_its_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
